### rtl/core/sthit_pkg.sv
// Package: types, codes and constants for the shape table hit test block.
`default_nettype none

package sthit_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int TABLE_ENTRIES_MAX = 256;
  // wide enough to compare any index or count against the table depth
  localparam int CMP_W = 9;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e_t;

  typedef enum logic [1:0] {
    SHAPE_EMPTY  = 2'd0,
    SHAPE_RECT   = 2'd1,
    SHAPE_CIRCLE = 2'd2
  } shape_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e_t;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         entry_index;
    logic [1:0]         shape_type;
    logic               control_role;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [14:0]        rect_length;
    logic [14:0]        rect_width;
    logic [22:0]        circle_radius;
  } in_word_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] hit_index;
    logic       hit_role;
  } out_word_t;

  typedef struct packed {
    logic               role;
    shape_e_t           shape;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [14:0]        len;
    logic [14:0]        wid;
    logic [22:0]        radius;
  } entry_t;

  typedef struct packed {
    logic       busy;
    logic       hit;
    logic [3:0] idx;
    logic       role;
  } eval_status_t;

endpackage

`default_nettype wire

### rtl/core/sthit_mem.sv
// Entry table: one synchronous memory plus per-entry written flags.
`default_nettype none

module sthit_mem #(
  parameter int TABLE_ENTRIES = sthit_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [IDX_W-1:0]      wr_addr,
  input  wire sthit_pkg::entry_t     wr_data,
  input  wire logic                  rd_en,
  input  wire logic [IDX_W-1:0]      rd_addr,
  output logic                       q_vld,
  output logic                       q_written,
  output logic [IDX_W-1:0]           q_addr,
  output sthit_pkg::entry_t          q_data
);

  sthit_pkg::entry_t          entry_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   valid_r;
  logic                       q_vld_r;
  logic                       q_written_r;
  logic [IDX_W-1:0]           q_addr_r;
  sthit_pkg::entry_t          q_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_data_r <= entry_mem[rd_addr];
      q_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      q_vld_r     <= 1'b0;
      q_written_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      q_vld_r <= rd_en;
      if (rd_en) begin
        q_written_r <= valid_r[rd_addr];
      end
    end
  end

  assign q_vld     = q_vld_r;
  assign q_written = q_written_r;
  assign q_addr    = q_addr_r;
  assign q_data    = q_data_r;

endmodule

`default_nettype wire

### rtl/core/sthit_eval.sv
// Containment pipeline: offsets, squares, compare and first-hit capture.
`default_nettype none

module sthit_eval #(
  parameter int TABLE_ENTRIES = sthit_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    clear,
  input  wire logic signed [15:0]      px,
  input  wire logic signed [15:0]      py,
  input  wire logic                    q_vld,
  input  wire logic                    q_written,
  input  wire logic [IDX_W-1:0]        q_addr,
  input  wire sthit_pkg::entry_t       q_data,
  output sthit_pkg::eval_status_t      status
);

  // stage 1: offsets and rectangle test
  sthit_pkg::shape_e_t       shape_w;
  logic signed [16:0]        dx_w;
  logic signed [16:0]        dy_w;
  logic                      rect_in_w;

  logic                      s1_vld_r;
  logic [IDX_W-1:0]          s1_idx_r;
  logic                      s1_role_r;
  logic                      s1_rect_r;
  logic                      s1_circ_r;
  logic signed [16:0]        s1_dx_r;
  logic signed [16:0]        s1_dy_r;
  logic [22:0]               s1_rad_r;

  // stage 2: squares
  logic signed [33:0]        dx_sq_w;
  logic signed [33:0]        dy_sq_w;
  logic [45:0]               r_sq_w;

  logic                      s2_vld_r;
  logic [IDX_W-1:0]          s2_idx_r;
  logic                      s2_role_r;
  logic                      s2_rect_r;
  logic                      s2_circ_r;
  logic [31:0]               s2_dx2_r;
  logic [31:0]               s2_dy2_r;
  logic [45:0]               s2_r2_r;

  // stage 3: circle compare and capture
  logic [32:0]               d2_w;
  logic                      circ_in_w;
  logic                      hit_w;

  logic                      found_r;
  logic [IDX_W-1:0]          found_idx_r;
  logic                      found_role_r;
  logic [sthit_pkg::CMP_W-1:0] idx_wide_w;

  assign shape_w = q_written ? q_data.shape : sthit_pkg::SHAPE_EMPTY;
  assign dx_w    = {px[15], px} - {q_data.ox[15], q_data.ox};
  assign dy_w    = {py[15], py} - {q_data.oy[15], q_data.oy};
  assign rect_in_w = !dx_w[16] && (dx_w[15:0] <= {1'b0, q_data.len}) &&
                     !dy_w[16] && (dy_w[15:0] <= {1'b0, q_data.wid});

  always_ff @(posedge clk) begin
    s1_idx_r  <= q_addr;
    s1_role_r <= q_data.role;
    s1_rect_r <= (shape_w == sthit_pkg::SHAPE_RECT) && rect_in_w;
    s1_circ_r <= (shape_w == sthit_pkg::SHAPE_CIRCLE);
    s1_dx_r   <= dx_w;
    s1_dy_r   <= dy_w;
    s1_rad_r  <= q_data.radius;
  end

  assign dx_sq_w = 34'(s1_dx_r) * 34'(s1_dx_r);
  assign dy_sq_w = 34'(s1_dy_r) * 34'(s1_dy_r);
  assign r_sq_w  = 46'(s1_rad_r) * 46'(s1_rad_r);

  always_ff @(posedge clk) begin
    s2_idx_r  <= s1_idx_r;
    s2_role_r <= s1_role_r;
    s2_rect_r <= s1_rect_r;
    s2_circ_r <= s1_circ_r;
    s2_dx2_r  <= dx_sq_w[31:0];
    s2_dy2_r  <= dy_sq_w[31:0];
    s2_r2_r   <= r_sq_w;
  end

  // d2 * 2^16 <= r2  is the same as  d2 <= floor(r2 / 2^16)
  assign d2_w      = {1'b0, s2_dx2_r} + {1'b0, s2_dy2_r};
  assign circ_in_w = d2_w <= {3'b000, s2_r2_r[45:16]};
  assign hit_w     = s2_rect_r || (s2_circ_r && circ_in_w);

  always_ff @(posedge clk) begin
    if (s2_vld_r && hit_w && !found_r) begin
      found_idx_r  <= s2_idx_r;
      found_role_r <= s2_role_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      s1_vld_r <= q_vld;
      s2_vld_r <= s1_vld_r;
      if (clear) begin
        found_r <= 1'b0;
      end else if (s2_vld_r && hit_w) begin
        found_r <= 1'b1;
      end
    end
  end

  assign idx_wide_w  = sthit_pkg::CMP_W'(found_idx_r);
  assign status.busy = q_vld || s1_vld_r || s2_vld_r;
  assign status.hit  = found_r;
  assign status.idx  = found_r ? idx_wide_w[3:0] : 4'd0;
  assign status.role = found_r ? found_role_r : 1'b0;

endmodule

`default_nettype wire

### rtl/core/shape_table_hit_test_top.sv
// Top level: command port, entry loads, query scan sequencer and result word.
//
//   channel | signals                      | handshake
//   input   | start, busy, in_word         | taken when start && !busy
//   result  | out_strobe, out_word         | one-cycle strobe, no back-pressure
//   config  | cfg_we, cfg_wdata            | written when cfg_we
//
// A load leaves busy low. A query reads one table entry per cycle from the
// highest index in use down, through a three-stage compare pipeline behind the
// memory's registered read, and the next word is taken in the cycle after the
// result strobe. The receiver cannot stall.
// Reset is synchronous, active low, and marks every entry empty at once.
`default_nettype none

module shape_table_hit_test_top #(
  parameter int TABLE_ENTRIES = sthit_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire sthit_pkg::in_word_t in_word,
  output logic                     out_strobe,
  output sthit_pkg::out_word_t     out_word,
  input  wire logic                cfg_we,
  input  wire logic [4:0]          cfg_wdata
);

  sthit_pkg::state_e_t         state_r;
  sthit_pkg::state_e_t         state_nxt;
  logic [4:0]                  eiu_r;
  logic [CNT_W-1:0]            scan_cnt_r;
  logic [CNT_W-1:0]            scan_cnt_nxt;
  logic signed [15:0]          px_r;
  logic signed [15:0]          py_r;

  logic                        accept_w;
  logic                        query_w;
  logic                        load_w;
  logic [sthit_pkg::CMP_W-1:0] ld_wide_w;
  logic [sthit_pkg::CMP_W-1:0] cnt_wide_w;
  logic [CNT_W-1:0]            dec_w;
  sthit_pkg::entry_t           wr_data_w;

  logic                        rd_en_w;
  logic [IDX_W-1:0]            rd_addr_w;
  logic                        q_vld_w;
  logic                        q_written_w;
  logic [IDX_W-1:0]            q_addr_w;
  sthit_pkg::entry_t           q_data_w;
  sthit_pkg::eval_status_t     status_w;

  assign accept_w = start && !busy;
  assign query_w  = accept_w && (in_word.opcode == sthit_pkg::OP_QUERY);
  assign ld_wide_w = sthit_pkg::CMP_W'(in_word.entry_index);
  assign load_w   = accept_w && (in_word.opcode == sthit_pkg::OP_LOAD) &&
                    (ld_wide_w < sthit_pkg::CMP_W'(TABLE_ENTRIES));

  always_comb begin
    wr_data_w.role   = in_word.control_role;
    wr_data_w.ox     = in_word.coord_x;
    wr_data_w.oy     = in_word.coord_y;
    wr_data_w.len    = in_word.rect_length;
    wr_data_w.wid    = in_word.rect_width;
    wr_data_w.radius = in_word.circle_radius;
    unique case (in_word.shape_type)
      sthit_pkg::SHAPE_RECT:   wr_data_w.shape = sthit_pkg::SHAPE_RECT;
      sthit_pkg::SHAPE_CIRCLE: wr_data_w.shape = sthit_pkg::SHAPE_CIRCLE;
      default:                 wr_data_w.shape = sthit_pkg::SHAPE_EMPTY;
    endcase
  end

  assign cnt_wide_w = (sthit_pkg::CMP_W'(eiu_r) > sthit_pkg::CMP_W'(TABLE_ENTRIES)) ?
                      sthit_pkg::CMP_W'(TABLE_ENTRIES) : sthit_pkg::CMP_W'(eiu_r);
  assign dec_w      = scan_cnt_r - CNT_W'(1);
  assign rd_addr_w  = dec_w[IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sthit_pkg::ST_IDLE: begin
        if (query_w) state_nxt = sthit_pkg::ST_SCAN;
      end
      sthit_pkg::ST_SCAN: begin
        if (scan_cnt_r <= CNT_W'(1)) state_nxt = sthit_pkg::ST_DRAIN;
      end
      sthit_pkg::ST_DRAIN: begin
        if (!status_w.busy) state_nxt = sthit_pkg::ST_DONE;
      end
      sthit_pkg::ST_DONE: begin
        state_nxt = sthit_pkg::ST_IDLE;
      end
      default: state_nxt = sthit_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    rd_en_w    = 1'b0;
    out_strobe = 1'b0;
    unique case (state_r)
      sthit_pkg::ST_IDLE:  busy = 1'b0;
      sthit_pkg::ST_SCAN:  rd_en_w = (scan_cnt_r != '0);
      sthit_pkg::ST_DRAIN: busy = 1'b1;
      sthit_pkg::ST_DONE:  out_strobe = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

  always_comb begin
    scan_cnt_nxt = scan_cnt_r;
    if (query_w) begin
      scan_cnt_nxt = cnt_wide_w[CNT_W-1:0];
    end else if (rd_en_w) begin
      scan_cnt_nxt = dec_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sthit_pkg::ST_IDLE;
      eiu_r      <= 5'd0;
      scan_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      if (cfg_we) begin
        eiu_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_w) begin
      px_r <= in_word.coord_x;
      py_r <= in_word.coord_y;
    end
  end

  sthit_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (load_w),
    .wr_addr   (ld_wide_w[IDX_W-1:0]),
    .wr_data   (wr_data_w),
    .rd_en     (rd_en_w),
    .rd_addr   (rd_addr_w),
    .q_vld     (q_vld_w),
    .q_written (q_written_w),
    .q_addr    (q_addr_w),
    .q_data    (q_data_w)
  );

  sthit_eval #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (query_w),
    .px        (px_r),
    .py        (py_r),
    .q_vld     (q_vld_w),
    .q_written (q_written_w),
    .q_addr    (q_addr_w),
    .q_data    (q_data_w),
    .status    (status_w)
  );

  assign out_word.hit       = status_w.hit;
  assign out_word.hit_index = status_w.idx;
  assign out_word.hit_role  = status_w.role;

endmodule

`default_nettype wire

### test/shape_table_hit_test_top_tb.sv
// Testbench for shape_table_hit_test_top: directed and random load/query words checked against a predictor.
`default_nettype none

module shape_table_hit_test_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sthit_pkg::*;

  localparam int TBL_DEPTH = TABLE_ENTRIES_DEF;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_PHASES = 7;
  localparam int WORDS_PER_PHASE = 100;
  localparam logic [1:0] SHAPE_UNKNOWN = 2'd3;
  localparam logic ROLE_MENU = 1'b0;
  localparam logic ROLE_BUTTON = 1'b1;
  localparam out_word_t NO_HIT = '0;

  typedef enum logic { ROW_WORD, ROW_CFG } row_kind_e_t;

  typedef struct {
    row_kind_e_t kind;
    in_word_t    word;
    logic [4:0]  cfg_value;
    bit          typed;
    out_word_t   want;
  } probe_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_word_t   in_word = '0;
  logic       out_strobe;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  // shadow table and register
  logic [4:0]         entries_used;
  shape_e_t           tbl_shape [TBL_DEPTH];
  logic               tbl_role  [TBL_DEPTH];
  logic signed [15:0] tbl_ox    [TBL_DEPTH];
  logic signed [15:0] tbl_oy    [TBL_DEPTH];
  logic [14:0]        tbl_len   [TBL_DEPTH];
  logic [14:0]        tbl_wid   [TBL_DEPTH];
  logic [22:0]        tbl_rad   [TBL_DEPTH];

  out_word_t  pending_hits [$];
  probe_row_t probe_rows [$];
  int         mismatches = 0;

  logic [4:0] phase_counts [RANDOM_PHASES] = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd8, 5'd15, 5'd16};

  shape_table_hit_test_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_word_t predict_hit(logic signed [15:0] px, logic signed [15:0] py);
    out_word_t res;
    int count;
    longint dx, dy, r;
    bit holds;
    res = NO_HIT;
    count = (entries_used > TBL_DEPTH) ? TBL_DEPTH : int'(entries_used);
    for (int i = count - 1; i >= 0; i--) begin
      dx = longint'(px) - longint'(tbl_ox[i]);
      dy = longint'(py) - longint'(tbl_oy[i]);
      r = longint'(tbl_rad[i]);
      case (tbl_shape[i])
        SHAPE_RECT: holds = dx >= 0 && dx <= longint'(tbl_len[i]) &&
                            dy >= 0 && dy <= longint'(tbl_wid[i]);
        SHAPE_CIRCLE: holds = ((dx * dx + dy * dy) << 16) <= r * r;
        default: holds = 1'b0;
      endcase
      if (holds) begin
        res.hit = 1'b1;
        res.hit_index = 4'(i);
        res.hit_role = tbl_role[i];
        break;
      end
    end
    return res;
  endfunction

  function automatic void store_entry(in_word_t w);
    tbl_shape[w.entry_index] = (w.shape_type == SHAPE_UNKNOWN) ? SHAPE_EMPTY
                                                               : shape_e_t'(w.shape_type);
    tbl_role[w.entry_index] = w.control_role;
    tbl_ox[w.entry_index] = w.coord_x;
    tbl_oy[w.entry_index] = w.coord_y;
    tbl_len[w.entry_index] = w.rect_length;
    tbl_wid[w.entry_index] = w.rect_width;
    tbl_rad[w.entry_index] = w.circle_radius;
  endfunction

  function automatic in_word_t load_word(logic [3:0] idx, logic [1:0] shape, logic role,
                                         int x, int y, int len, int wid, int rad);
    in_word_t w;
    w = '0;
    w.opcode = OP_LOAD;
    w.entry_index = idx;
    w.shape_type = shape;
    w.control_role = role;
    w.coord_x = 16'(x);
    w.coord_y = 16'(y);
    w.rect_length = 15'(len);
    w.rect_width = 15'(wid);
    w.circle_radius = 23'(rad);
    return w;
  endfunction

  function automatic in_word_t query_word(int x, int y);
    in_word_t w;
    w = '0;
    w.opcode = OP_QUERY;
    w.coord_x = 16'(x);
    w.coord_y = 16'(y);
    return w;
  endfunction

  function automatic void add_word(in_word_t w, bit typed = 1'b0, out_word_t want = NO_HIT);
    probe_row_t row;
    row.kind = ROW_WORD;
    row.word = w;
    row.cfg_value = '0;
    row.typed = typed;
    row.want = want;
    probe_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [4:0] v);
    probe_row_t row;
    row.kind = ROW_CFG;
    row.word = '0;
    row.cfg_value = v;
    row.typed = 1'b0;
    row.want = NO_HIT;
    probe_rows.push_back(row);
  endfunction

  // compact words keep shapes and points close together so that hits are common
  function automatic in_word_t random_word(bit compact);
    logic [95:0] raw;
    in_word_t w;
    int k;
    raw = {$urandom(), $urandom(), $urandom()};
    w = raw[$bits(in_word_t)-1:0];
    w.opcode = ($urandom_range(0, 99) < 40) ? OP_LOAD : OP_QUERY;
    if (w.opcode == OP_LOAD) begin
      case ($urandom_range(0, 9))
        0: w.shape_type = SHAPE_EMPTY;
        1: w.shape_type = SHAPE_UNKNOWN;
        2, 3, 4, 5: w.shape_type = SHAPE_RECT;
        default: w.shape_type = SHAPE_CIRCLE;
      endcase
      if (compact) begin
        w.coord_x = 16'($urandom_range(0, 200) - 100);
        w.coord_y = 16'($urandom_range(0, 200) - 100);
        w.rect_length = 15'($urandom_range(0, 60));
        w.rect_width = 15'($urandom_range(0, 60));
        w.circle_radius = 23'($urandom_range(0, 60 * 256));
      end
    end else if ($urandom_range(0, 1)) begin
      k = $urandom_range(0, TBL_DEPTH - 1);
      w.coord_x = tbl_ox[k] + 16'($urandom_range(0, 80) - 40);
      w.coord_y = tbl_oy[k] + 16'($urandom_range(0, 80) - 40);
    end else if (compact) begin
      w.coord_x = 16'($urandom_range(0, 200) - 100);
      w.coord_y = 16'($urandom_range(0, 200) - 100);
    end
    return w;
  endfunction

  // start stays high across back-to-back words
  task automatic send_word(in_word_t w, int gap, bit typed, out_word_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w.opcode == OP_LOAD) store_entry(w);
    else pending_hits.push_back(typed ? want : predict_hit(w.coord_x, w.coord_y));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entries_used(logic [4:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    entries_used = v;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_strobe) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %p", $time, out_word);
        mismatches++;
      end else begin
        want = pending_hits.pop_front();
        if (out_word.hit !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, out_word.hit);
          mismatches++;
        end
        if (out_word.hit_index !== want.hit_index) begin
          $display("%0t: hit_index expected %0d actual %0d", $time, want.hit_index,
                   out_word.hit_index);
          mismatches++;
        end
        if (out_word.hit_role !== want.hit_role) begin
          $display("%0t: hit_role expected %0d actual %0d", $time, want.hit_role,
                   out_word.hit_role);
          mismatches++;
        end
      end
    end
  end

  initial begin
    bit burst;
    entries_used = '0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tbl_shape[i] = SHAPE_EMPTY;
      tbl_role[i] = ROLE_MENU;
      tbl_ox[i] = '0;
      tbl_oy[i] = '0;
      tbl_len[i] = '0;
      tbl_wid[i] = '0;
      tbl_rad[i] = '0;
    end

    // nothing in use after reset
    add_word(query_word(0, 0), 1'b1, NO_HIT);
    add_word(query_word(-32768, 32767), 1'b1, NO_HIT);
    // count above the table depth, every entry still empty
    add_cfg(5'd31);
    add_word(query_word(0, 0), 1'b1, NO_HIT);
    // full-extent rectangles at both corners
    add_word(load_word(4'd0, SHAPE_RECT, ROLE_MENU, -32768, -32768, 32767, 32767, 0));
    add_word(load_word(4'd15, SHAPE_RECT, ROLE_BUTTON, 32767, 32767, 32767, 32767, 0));
    add_word(query_word(32767, 32767), 1'b1, '{hit: 1'b1, hit_index: 4'd15,
                                               hit_role: ROLE_BUTTON});
    add_word(query_word(-32768, -32768), 1'b1, '{hit: 1'b1, hit_index: 4'd0,
                                                 hit_role: ROLE_MENU});
    add_word(query_word(-1, -1));
    add_word(query_word(0, -1));
    // largest radius, then a circle tested right on its rim
    add_word(load_word(4'd7, SHAPE_CIRCLE, ROLE_BUTTON, 0, 0, 0, 0, 8388607));
    add_word(query_word(32767, -32768));
    add_word(query_word(100, 100));
    add_word(load_word(4'd8, SHAPE_CIRCLE, ROLE_MENU, 10, 0, 0, 0, 5 * 256));
    add_word(query_word(15, 0));
    // zero radius, unknown shape and empty entry on the same point
    add_word(load_word(4'd9, SHAPE_CIRCLE, ROLE_BUTTON, 3, 3, 0, 0, 0));
    add_word(query_word(3, 3));
    add_word(load_word(4'd10, SHAPE_UNKNOWN, ROLE_BUTTON, 3, 3, 100, 100, 5000));
    add_word(query_word(3, 3));
    add_word(load_word(4'd11, SHAPE_EMPTY, ROLE_BUTTON, 3, 3, 100, 100, 5000));
    add_word(query_word(3, 3));
    add_cfg(5'd9);
    add_word(query_word(3, 3));
    add_cfg(5'd0);
    add_word(query_word(3, 3), 1'b1, NO_HIT);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_rows[n]) begin
      if (probe_rows[n].kind == ROW_CFG) begin
        write_entries_used(probe_rows[n].cfg_value);
      end else begin
        send_word(probe_rows[n].word, $urandom_range(0, 4), probe_rows[n].typed,
                  probe_rows[n].want);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_entries_used(phase_counts[p]);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 25 == 0) burst = ($urandom_range(0, 3) == 0);
        send_word(random_word($urandom_range(0, 9) < 8), burst ? 0 : $urandom_range(0, 4),
                  1'b0, NO_HIT);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("shape_table_hit_test_top_tb: done, clean");
    end else begin
      $display("shape_table_hit_test_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("shape_table_hit_test_top_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
